/* rtl/tdc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tdc_pkg
// shared types and codes of the expiring decision cache
// ----------------------------------------------------------------------------
package tdc_pkg;

  localparam int unsigned REQ_W = 3;
  localparam int unsigned PID_W = 23;
  localparam int unsigned OBJ_W = 64;
  localparam int unsigned ACC_W = 2;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned CNT_W = 9;
  localparam int unsigned TTL_W = 16;
  localparam logic [TTL_W-1:0] TTL_RESET = 16'd100;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP = 3'd0,
    REQ_STORE  = 3'd1,
    REQ_INVAL  = 3'd2,
    REQ_FLUSH  = 3'd3,
    REQ_TICK   = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_HIT    = 3'd0,
    ST_STALE  = 3'd1,
    ST_MISS   = 3'd2,
    ST_STORED = 3'd3,
    ST_FULL   = 3'd4,
    ST_DENY   = 3'd5,
    ST_INVAL  = 3'd6,
    ST_DONE   = 3'd7
  } status_t;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_LOOKUP,
    OP_STORE,
    OP_INVAL,
    OP_FLUSH,
    OP_IMM
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [STAT_W-1:0]   imm_status;
    logic [PID_W-1:0]    pid;
    logic [OBJ_W-1:0]    obj;
    logic [ACC_W-1:0]    acc;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DONE
  } bk_state_t;

endpackage
`default_nettype wire

/* rtl/tdc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tdc_front
// accepts requests, classifies them and pushes commands into a small queue
// ----------------------------------------------------------------------------
module tdc_front
  import tdc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire logic [REQ_W-1:0]  req_type,
  input  wire logic [PID_W-1:0]  proc_id,
  input  wire logic [OBJ_W-1:0]  object_id,
  input  wire logic [ACC_W-1:0]  access_mask,
  input  wire logic              verdict,
  input  wire logic              pop,
  output logic                   q_valid,
  output cmd_t                   q_cmd,
  output logic                   q_full,
  output logic                   tick
);

  cmd_t cmd_nxt;
  cmd_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  always_comb begin
    cmd_nxt.pid = proc_id;
    cmd_nxt.obj = object_id;
    cmd_nxt.acc = access_mask;
    cmd_nxt.imm_status = ST_DONE;
    tick = 1'b0;
    case (req_type)
      REQ_LOOKUP: cmd_nxt.op = OP_LOOKUP;
      REQ_STORE: begin
        if (verdict) begin
          cmd_nxt.op = OP_IMM;
          cmd_nxt.imm_status = ST_DENY;
        end else begin
          cmd_nxt.op = OP_STORE;
        end
      end
      REQ_INVAL: cmd_nxt.op = OP_INVAL;
      REQ_FLUSH: cmd_nxt.op = OP_FLUSH;
      REQ_TICK: begin
        cmd_nxt.op = OP_IMM;
        tick = take;
      end
      default: cmd_nxt.op = OP_IMM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) mem_r[wp_r] <= cmd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (take) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, take} - {1'b0, pop};
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_full = (cnt_r == 2'd2);
  assign q_cmd = mem_r[rp_r];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(take && q_full && !pop)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");

endmodule
`default_nettype wire

/* rtl/tdc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tdc_back
// table of entries: one slot per cycle scan for lookup, store, invalidate, flush
// ----------------------------------------------------------------------------
module tdc_back
  import tdc_pkg::*;
#(
  parameter int unsigned ENTRIES   = 256,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  input  cmd_t                      q_cmd,
  output logic                      pop,
  input  wire logic [TIME_BITS-1:0] now,
  input  wire logic [TTL_W-1:0]     ttl,
  output logic                      res_valid,
  output logic [STAT_W-1:0]         res_status,
  output logic [CNT_W-1:0]          res_count
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CTR_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // valid bits in flops; payload in memory read one slot per cycle
  logic [ENTRIES-1:0]   valid_r;
  logic [PID_W-1:0]     m_pid   [ENTRIES];
  logic [OBJ_W-1:0]     m_obj   [ENTRIES];
  logic [ACC_W-1:0]     m_acc   [ENTRIES];
  logic [TIME_BITS-1:0] m_exp   [ENTRIES];

  bk_state_t st_r, st_nxt;
  cmd_t cur_r;
  logic [CTR_W-1:0] idx_r, idx_nxt;     // read address counter
  logic             rd_v_r;             // read data valid this cycle
  logic [IDX_W-1:0] rd_idx_r;
  logic [PID_W-1:0] rd_pid_r;
  logic [OBJ_W-1:0] rd_obj_r;
  logic [ACC_W-1:0] rd_acc_r;
  logic [TIME_BITS-1:0] rd_exp_r;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic             hit_exp_r, hit_exp_nxt;
  logic             free_r, free_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic             out_v_r, out_v_nxt;

  logic rd_en, last_rd, key_eq, expired, inv_m, clr, wr_en;
  logic [TIME_BITS-1:0] diff;
  logic [IDX_W-1:0] wr_idx;
  logic [ENTRIES-1:0] clr_mask;

  assign diff    = now - rd_exp_r;
  assign expired = ~diff[TIME_BITS-1];
  assign key_eq  = valid_r[rd_idx_r] && rd_pid_r == cur_r.pid &&
                   rd_obj_r == cur_r.obj && rd_acc_r == cur_r.acc;
  assign inv_m   = valid_r[rd_idx_r] &&
                   (cur_r.pid == '0 || rd_pid_r == cur_r.pid) &&
                   (cur_r.obj == '0 || rd_obj_r == cur_r.obj);
  assign last_rd = rd_v_r && (rd_idx_r == IDX_W'(ENTRIES - 1));

  always_comb begin
    clr = 1'b0;
    if (rd_v_r) begin
      case (cur_r.op)
        OP_INVAL: clr = inv_m;
        OP_FLUSH: clr = valid_r[rd_idx_r] && expired;
        default:  clr = 1'b0;
      endcase
    end
  end

  always_comb begin
    st_nxt = st_r;
    pop = 1'b0;
    idx_nxt = idx_r;
    rd_en = 1'b0;
    hit_nxt = hit_r;
    hit_idx_nxt = hit_idx_r;
    hit_exp_nxt = hit_exp_r;
    free_nxt = free_r;
    free_idx_nxt = free_idx_r;
    cnt_nxt = cnt_r;
    stat_nxt = stat_r;
    out_v_nxt = 1'b0;
    wr_en = 1'b0;
    wr_idx = hit_idx_r;
    case (st_r)
      BK_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          idx_nxt = '0;
          hit_nxt = 1'b0;
          free_nxt = 1'b0;
          cnt_nxt = '0;
          if (q_cmd.op == OP_IMM) begin
            stat_nxt = q_cmd.imm_status;
            out_v_nxt = 1'b1;
          end else begin
            st_nxt = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        if (idx_r < CTR_W'(ENTRIES)) begin
          rd_en = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
        if (rd_v_r) begin
          if (key_eq && !hit_r) begin
            hit_nxt = 1'b1;
            hit_idx_nxt = rd_idx_r;
            hit_exp_nxt = expired;
          end
          if (!valid_r[rd_idx_r] && !free_r) begin
            free_nxt = 1'b1;
            free_idx_nxt = rd_idx_r;
          end
          if (clr && cnt_r != CNT_MAX) cnt_nxt = cnt_r + 1'b1;
        end
        if (last_rd) st_nxt = BK_DONE;
      end
      BK_DONE: begin
        st_nxt = BK_IDLE;
        out_v_nxt = 1'b1;
        case (cur_r.op)
          OP_LOOKUP: stat_nxt = !hit_r ? ST_MISS : (hit_exp_r ? ST_STALE : ST_HIT);
          OP_STORE: begin
            if (hit_r || free_r) begin
              wr_en = 1'b1;
              wr_idx = hit_r ? hit_idx_r : free_idx_r;
              stat_nxt = ST_STORED;
            end else begin
              stat_nxt = ST_FULL;
            end
          end
          OP_INVAL: stat_nxt = ST_INVAL;
          default:  stat_nxt = ST_DONE;
        endcase
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    clr_mask = '0;
    clr_mask[rd_idx_r] = clr;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_pid_r <= m_pid[idx_r[IDX_W-1:0]];
      rd_obj_r <= m_obj[idx_r[IDX_W-1:0]];
      rd_acc_r <= m_acc[idx_r[IDX_W-1:0]];
      rd_exp_r <= m_exp[idx_r[IDX_W-1:0]];
    end
    if (wr_en) begin
      m_pid[wr_idx] <= cur_r.pid;
      m_obj[wr_idx] <= cur_r.obj;
      m_acc[wr_idx] <= cur_r.acc;
      m_exp[wr_idx] <= now + TIME_BITS'(ttl);
    end
    rd_idx_r <= idx_r[IDX_W-1:0];
    if (pop) cur_r <= q_cmd;
    hit_idx_r <= hit_idx_nxt;
    hit_exp_r <= hit_exp_nxt;
    free_idx_r <= free_idx_nxt;
    stat_r <= stat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      valid_r <= '0;
      idx_r <= '0;
      rd_v_r <= 1'b0;
      hit_r <= 1'b0;
      free_r <= 1'b0;
      cnt_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      rd_v_r <= rd_en;
      hit_r <= hit_nxt;
      free_r <= free_nxt;
      cnt_r <= cnt_nxt;
      out_v_r <= out_v_nxt;
      valid_r <= (valid_r & ~clr_mask) |
                 ({{(ENTRIES-1){1'b0}}, wr_en} << wr_idx);
    end
  end

  assign res_valid  = out_v_r;
  assign res_status = stat_r;
  assign res_count  = cnt_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> st_r == BK_IDLE) else $error("pop outside idle");
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == BK_DONE |=> res_valid) else $error("missing result after scan");
  a_no_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> st_r == BK_DONE) else $error("table write during scan");

endmodule
`default_nettype wire

/* rtl/ttl_decision_cache_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ttl_decision_cache_core
// associative cache of allow decisions with expiry times
//
//  channel | ports                                         | transfer when
//  in      | start, busy, in_req_type..in_verdict          | start && !busy
//  out     | out_valid, out_status, out_removed_count      | out_valid
//  cfg     | cfg_we, cfg_ttl_ticks                         | cfg_we
//
// tick, unused codes and deny stores are answered from the idle state with no scan;
// lookup, store, invalidate and flush scan the table one slot per cycle.
// the scan length is set by the single-port table memory.
// rst_n is synchronous; the table comes up empty with no clearing pass.
// busy rises when the two-deep command queue is full; results cannot stall.
// ----------------------------------------------------------------------------
module ttl_decision_cache_core
  import tdc_pkg::*;
#(
  parameter int unsigned ENTRIES   = 256,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [REQ_W-1:0]  in_req_type,
  input  wire logic [PID_W-1:0]  in_proc_id,
  input  wire logic [OBJ_W-1:0]  in_object_id,
  input  wire logic [ACC_W-1:0]  in_access_mask,
  input  wire logic              in_verdict,
  output logic                   out_valid,
  output logic [STAT_W-1:0]      out_status,
  output logic [CNT_W-1:0]       out_removed_count,
  input  wire logic              cfg_we,
  input  wire logic [TTL_W-1:0]  cfg_ttl_ticks
);

  logic [TTL_W-1:0] ttl_r;
  logic [TIME_BITS-1:0] now_r;
  logic take, pop, q_valid, q_full, tick;
  cmd_t q_cmd;
  logic [TIME_BITS-1:0] bk_now_r;
  // count of ticks accepted but not yet passed through the back end
  logic [1:0] tick_pend_r;
  logic tick_pop;
  logic [1:0] tk_head_r;
  logic wr_tk_r, rd_tk_r;

  assign busy = q_full;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= TTL_RESET;
      now_r <= '0;
    end else begin
      if (cfg_we) ttl_r <= cfg_ttl_ticks;
      // time advances at accept; the back end sees ordering through the queue
      if (tick) now_r <= now_r + 1'b1;
    end
  end

  tdc_front u_front (
    .clk(clk), .rst_n(rst_n), .take(take),
    .req_type(in_req_type), .proc_id(in_proc_id), .object_id(in_object_id),
    .access_mask(in_access_mask), .verdict(in_verdict),
    .pop(pop), .q_valid(q_valid), .q_cmd(q_cmd), .q_full(q_full), .tick(tick)
  );

  // back end must see time as of its own command: hold ticks until drained
  always_ff @(posedge clk) begin
    if (!rst_n) bk_now_r <= '0;
    else if (tick_pop) bk_now_r <= bk_now_r + 1'b1;
  end

  // tick marks ride beside the command queue slots
  assign tick_pop = pop && tk_head_r[rd_tk_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_pend_r <= '0;
      wr_tk_r <= 1'b0;
      rd_tk_r <= 1'b0;
      tk_head_r <= '0;
    end else begin
      if (take) begin
        tk_head_r[wr_tk_r] <= tick;
        wr_tk_r <= ~wr_tk_r;
      end
      if (pop) rd_tk_r <= ~rd_tk_r;
      tick_pend_r <= tick_pend_r + {1'b0, tick} - {1'b0, tick_pop};
    end
  end

  tdc_back #(.ENTRIES(ENTRIES), .TIME_BITS(TIME_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .pop(pop),
    .now(bk_now_r), .ttl(ttl_r),
    .res_valid(out_valid), .res_status(out_status), .res_count(out_removed_count)
  );

  a_time_lead: assert property (@(posedge clk) disable iff (!rst_n)
    tick_pend_r != 2'd3) else $error("tick backlog out of range");
  a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !take) else $error("accept while busy");
  a_front_time: assert property (@(posedge clk) disable iff (!rst_n)
    tick_pend_r == 2'd0 |-> now_r == bk_now_r) else $error("time views diverge");

endmodule
`default_nettype wire
